// File: hdl/cbhc_pkg.sv
// Shared types and constants of the cell balance hysteresis controller.
package cbhc_pkg;

    localparam int VOLT_W    = 16;
    localparam int CFG_IDX_W = 2;

    typedef logic [VOLT_W-1:0] volt_t;

    // Event kinds carried on the input tuser.
    localparam logic [1:0] FUNC_START  = 2'd0;
    localparam logic [1:0] FUNC_STOP   = 2'd1;
    localparam logic [1:0] FUNC_UPDATE = 2'd2;
    localparam logic [1:0] FUNC_TICK   = 2'd3;

    // Configuration register indexes.
    localparam logic [CFG_IDX_W-1:0] REG_START_TH = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_END_TH   = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_CEILING  = 2'd2;
    localparam logic [CFG_IDX_W-1:0] REG_WAIT     = 2'd3;

    // Wait timer phases.
    localparam logic [1:0] PH_IDLE  = 2'd0;
    localparam logic [1:0] PH_COUNT = 2'd1;
    localparam logic [1:0] PH_DONE  = 2'd2;

    // Configuration reset values.
    localparam volt_t START_TH_RST = 16'd20;
    localparam volt_t END_TH_RST   = 16'd5;
    localparam volt_t CEILING_RST  = 16'd5000;
    localparam volt_t WAIT_RST     = 16'd1000;

    // What one cell lane reports to the merging stage.
    typedef struct packed {
        logic start_hit;
        logic flag_next;
    } lane_res_t;

endpackage

// File: hdl/cbhc_min.sv
// Pack minimum search, seeded with the voltage ceiling.
module cbhc_min #(
    parameter int NUM_CELLS = 4
) (
    input  cbhc_pkg::volt_t ceiling,
    input  cbhc_pkg::volt_t volts [NUM_CELLS],
    output cbhc_pkg::volt_t min_volt
);
    import cbhc_pkg::*;

    volt_t acc;

    always_comb
    begin
        acc = ceiling;
        for (int i = 0; i < NUM_CELLS; i++)
        begin
            if (volts[i] < acc)
            begin
                acc = volts[i];
            end
        end
    end

    assign min_volt = acc;

endmodule

// File: hdl/cbhc_lane.sv
// One cell lane: excess over the pack minimum and the hysteresis flag update.
module cbhc_lane (
    input  cbhc_pkg::volt_t   volt,
    input  cbhc_pkg::volt_t   min_volt,
    input  cbhc_pkg::volt_t   start_th,
    input  cbhc_pkg::volt_t   end_th,
    input  logic              flag,
    output cbhc_pkg::lane_res_t res
);
    import cbhc_pkg::*;

    volt_t excess;

    // The minimum never exceeds this cell's voltage, so the difference cannot wrap.
    assign excess = volt - min_volt;

    always_comb
    begin
        res.start_hit = (excess > start_th);
        if (excess > start_th)
        begin
            res.flag_next = 1'b1;
        end
        else if (excess < end_th)
        begin
            res.flag_next = 1'b0;
        end
        else
        begin
            res.flag_next = flag;
        end
    end

endmodule

// File: hdl/cell_balance_hysteresis_controller_unit.sv
// Top level of the cell balance hysteresis controller.
// Usage:
//   Events arrive on the s_ channel: s_tuser carries the kind (start, stop,
//   update, tick), s_tdata the cell voltages and the round-done status.
//   Every event gives exactly one result transaction on the m_ channel with
//   the command flags, the balance mask, the running flag and the wait flag.
//   Thresholds, voltage ceiling and wait length are written through the cfg_
//   channel, which is always ready; write only while no event is in flight.
//   The result is valid in the cycle after the input transaction. One event
//   per cycle is taken while the receiver keeps up: the minimum search over
//   NUM_CELLS cells, the per-cell lanes and the merge all settle within the
//   cycle of acceptance, and the result sits in a single output register.
//   When the receiver stalls, the result is held and s_tready stays low until
//   it is taken; s_tready follows m_tready in the same cycle when full.
//   Reset clears the enable, running, flags and timer, restores the register
//   defaults and empties the output register.
module cell_balance_hysteresis_controller_unit #(
    parameter int NUM_CELLS = 4
) (
    input  logic clk,
    input  logic rst_n,
    input  logic s_tvalid,
    output logic s_tready,
    // cell_voltage_0 .. cell_voltage_N-1 (16 bits each), round_done, zero fill
    input  logic [((NUM_CELLS*16+1+7)/8)*8-1:0] s_tdata,
    // func
    input  logic [1:0] s_tuser,
    output logic m_tvalid,
    input  logic m_tready,
    // apply_mask, stop_all, balance_mask (NUM_CELLS bits), balancing_active,
    // waiting, zero fill
    output logic [((NUM_CELLS+4+7)/8)*8-1:0] m_tdata,
    input  logic cfg_valid,
    output logic cfg_ready,
    input  logic [cbhc_pkg::CFG_IDX_W-1:0] cfg_index,
    input  logic [15:0] cfg_data
);
    import cbhc_pkg::*;

    localparam int OUT_W = ((NUM_CELLS + 4 + 7) / 8) * 8;
    localparam int RD_BIT = NUM_CELLS * VOLT_W;

    volt_t start_th_reg, end_th_reg, ceiling_reg, wait_reg;

    logic                 enabled_reg, enabled_next;
    logic                 running_reg, running_next;
    logic [NUM_CELLS-1:0] flags_reg, flags_next;
    logic [1:0]           phase_reg, phase_next;
    volt_t                count_reg, count_next;

    logic                 out_valid_reg;
    logic [OUT_W-1:0]     out_data_reg, out_data_next;

    volt_t                volts [NUM_CELLS];
    volt_t                min_volt;
    lane_res_t            lane_res [NUM_CELLS];
    logic [NUM_CELLS-1:0] eval_flags, eval_hits;
    logic                 round_done;
    logic                 accept;
    logic                 do_eval, apply, stop;

    assign cfg_ready = 1'b1;
    assign s_tready  = !out_valid_reg || m_tready;
    assign accept    = s_tvalid && s_tready;
    assign round_done = s_tdata[RD_BIT];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            start_th_reg <= START_TH_RST;
            end_th_reg   <= END_TH_RST;
            ceiling_reg  <= CEILING_RST;
            wait_reg     <= WAIT_RST;
        end
        else if (cfg_valid)
        begin
            unique case (cfg_index)
                REG_START_TH: start_th_reg <= cfg_data;
                REG_END_TH:   end_th_reg   <= cfg_data;
                REG_CEILING:  ceiling_reg  <= cfg_data;
                REG_WAIT:     wait_reg     <= cfg_data;
                default:      ;
            endcase
        end
    end

    for (genvar g = 0; g < NUM_CELLS; g++)
    begin : g_lane
        assign volts[g] = s_tdata[g*VOLT_W +: VOLT_W];

        cbhc_lane u_lane (
            .volt     (volts[g]),
            .min_volt (min_volt),
            .start_th (start_th_reg),
            .end_th   (end_th_reg),
            .flag     (flags_reg[g]),
            .res      (lane_res[g])
        );

        assign eval_flags[g] = lane_res[g].flag_next;
        assign eval_hits[g]  = lane_res[g].start_hit;
    end

    cbhc_min #(
        .NUM_CELLS (NUM_CELLS)
    ) u_min (
        .ceiling  (ceiling_reg),
        .volts    (volts),
        .min_volt (min_volt)
    );

    // Event decode, merge of the lane results and the wait timer.
    always_comb
    begin
        enabled_next = enabled_reg;
        running_next = running_reg;
        flags_next   = flags_reg;
        phase_next   = phase_reg;
        count_next   = count_reg;
        do_eval      = 1'b0;
        stop         = 1'b0;

        unique case (s_tuser)
            FUNC_START:
            begin
                enabled_next = 1'b1;
                phase_next   = PH_IDLE;
                count_next   = '0;
                do_eval      = 1'b1;
            end
            FUNC_STOP:
            begin
                enabled_next = 1'b0;
                running_next = 1'b0;
                flags_next   = '0;
                stop         = 1'b1;
            end
            FUNC_UPDATE:
            begin
                if (enabled_reg)
                begin
                    if (!running_reg)
                    begin
                        do_eval = 1'b1;
                    end
                    else if (phase_reg == PH_DONE)
                    begin
                        do_eval    = 1'b1;
                        phase_next = PH_IDLE;
                        count_next = '0;
                    end
                    else if (round_done && phase_reg == PH_IDLE)
                    begin
                        phase_next = PH_COUNT;
                        count_next = wait_reg;
                    end
                end
            end
            FUNC_TICK:
            begin
                if (phase_reg == PH_COUNT)
                begin
                    if (count_reg <= 16'd1)
                    begin
                        count_next = '0;
                        phase_next = PH_DONE;
                    end
                    else
                    begin
                        count_next = count_reg - 16'd1;
                    end
                end
            end
            default: ;
        endcase

        apply = 1'b0;
        if (do_eval)
        begin
            flags_next = eval_flags;
            // A pattern is commanded when a cell crossed the start threshold
            // or balancing was already under way.
            if (running_reg || (|eval_hits))
            begin
                apply        = 1'b1;
                running_next = |eval_flags;
            end
        end

        out_data_next = '0;
        out_data_next[0] = apply;
        out_data_next[1] = stop;
        out_data_next[2 +: NUM_CELLS] = flags_next;
        out_data_next[2 + NUM_CELLS]  = running_next;
        out_data_next[3 + NUM_CELLS]  = (phase_next == PH_COUNT);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            enabled_reg   <= 1'b0;
            running_reg   <= 1'b0;
            flags_reg     <= '0;
            phase_reg     <= PH_IDLE;
            count_reg     <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (accept)
            begin
                enabled_reg   <= enabled_next;
                running_reg   <= running_next;
                flags_reg     <= flags_next;
                phase_reg     <= phase_next;
                count_reg     <= count_next;
                out_valid_reg <= 1'b1;
            end
            else if (m_tready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            out_data_reg <= out_data_next;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_data_reg;

endmodule

// File: hdl/cbhc_checker.sv
// Port-level checks of the cell balance hysteresis controller, bound to the top level.
module cbhc_checker #(
    parameter int NUM_CELLS = 4
) (
    input logic clk,
    input logic rst_n,
    input logic s_tvalid,
    input logic s_tready,
    input logic m_tvalid,
    input logic m_tready,
    input logic [((NUM_CELLS+4+7)/8)*8-1:0] m_tdata
);

    // Every input transaction shows up as a result in the following cycle.
    a_latency: assert property (@(posedge clk) disable iff (!rst_n)
        s_tvalid && s_tready |=> m_tvalid)
        else $error("input transaction without a result one cycle later");

    // A stalled result holds its value.
    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
        else $error("stalled result changed or dropped");

    // Balancing runs exactly when some cell is flagged.
    a_running_mask: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid |-> (m_tdata[2 + NUM_CELLS] == (|m_tdata[2 +: NUM_CELLS])))
        else $error("running flag disagrees with the balance mask");

    // A stop command clears the enable, the running flag and the mask and commands no new pattern.
    a_stop: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && m_tdata[1] |-> !m_tdata[0] && (m_tdata[2 +: NUM_CELLS] == '0))
        else $error("stop result carries a pattern");

endmodule

bind cell_balance_hysteresis_controller_unit cbhc_checker #(
    .NUM_CELLS (NUM_CELLS)
) u_cbhc_checker (
    .clk      (clk),
    .rst_n    (rst_n),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
);

// File: bench/cell_balance_hysteresis_controller_unit_tb.sv
// Self-checking testbench for the cell balance hysteresis controller.
`timescale 1ns / 1ps

module cell_balance_hysteresis_controller_unit_tb;

    import cbhc_pkg::*;

    localparam int CELLS     = 4;
    localparam int IN_W      = ((CELLS * 16 + 1 + 7) / 8) * 8;
    localparam int OUT_W     = ((CELLS + 4 + 7) / 8) * 8;
    localparam int CYCLE_CAP = 400000;

    typedef logic [CELLS-1:0][15:0] pack_volts_t;

    typedef struct packed {
        logic [1:0]  func;
        logic        round_done;
        pack_volts_t volts;
    } balance_event_t;

    logic             clk = 1'b0;
    logic             rst_n = 1'b0;
    logic             s_tvalid = 1'b0;
    logic             s_tready;
    logic [IN_W-1:0]  s_tdata = '0;
    logic [1:0]       s_tuser = FUNC_START;
    logic             m_tvalid;
    logic             m_tready = 1'b1;
    logic [OUT_W-1:0] m_tdata;
    logic             cfg_valid = 1'b0;
    logic             cfg_ready;
    logic [CFG_IDX_W-1:0] cfg_index = REG_START_TH;
    logic [15:0]      cfg_data = '0;

    // Predictor copy of the registers and the controller state.
    volt_t            start_th_q = START_TH_RST;
    volt_t            end_th_q   = END_TH_RST;
    volt_t            ceiling_q  = CEILING_RST;
    volt_t            wait_q     = WAIT_RST;
    logic             enabled_q  = 1'b0;
    logic             running_q  = 1'b0;
    logic [CELLS-1:0] flags_q    = '0;
    logic [1:0]       phase_q    = PH_IDLE;
    logic [15:0]      count_q    = '0;

    balance_event_t   pending_events[$];
    logic [OUT_W-1:0] due_command_words[$];
    balance_event_t   next_event;
    logic [OUT_W-1:0] want_word;
    logic             in_taken = 1'b0;
    logic             cfg_taken = 1'b0;
    logic             steady = 1'b0;
    int               errors = 0;
    int               cycles = 0;

    cell_balance_hysteresis_controller_unit #(
        .NUM_CELLS(CELLS)
    ) uut (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .cfg_valid(cfg_valid),
        .cfg_ready(cfg_ready),
        .cfg_index(cfg_index),
        .cfg_data (cfg_data)
    );

    always #10 clk = ~clk;

    // Minimum search from the ceiling, then the per-cell hysteresis decision.
    function automatic logic evaluate_pack(input pack_volts_t volts);
        volt_t floor_v;
        volt_t excess;
        floor_v = ceiling_q;
        for (int c = 0; c < CELLS; c++)
        begin
            if (volts[c] < floor_v)
                floor_v = volts[c];
        end
        for (int c = 0; c < CELLS; c++)
        begin
            excess = volts[c] - floor_v;
            if (excess > start_th_q)
            begin
                flags_q[c] = 1'b1;
                running_q  = 1'b1;
            end
            else if (excess < end_th_q)
                flags_q[c] = 1'b0;
        end
        if (!running_q)
            return 1'b0;
        // A pass that leaves no flag set still commands the empty mask.
        running_q = |flags_q;
        return 1'b1;
    endfunction

    function automatic logic [OUT_W-1:0] predict_balance_event(input balance_event_t ev);
        logic apply_q;
        logic stop_q;
        apply_q = 1'b0;
        stop_q  = 1'b0;
        case (ev.func)
            FUNC_START:
            begin
                phase_q   = PH_IDLE;
                count_q   = '0;
                enabled_q = 1'b1;
                apply_q   = evaluate_pack(ev.volts);
            end
            FUNC_STOP:
            begin
                enabled_q = 1'b0;
                running_q = 1'b0;
                flags_q   = '0;
                stop_q    = 1'b1;
            end
            FUNC_UPDATE:
            begin
                if (enabled_q)
                begin
                    if (!running_q)
                        apply_q = evaluate_pack(ev.volts);
                    else
                    begin
                        if (ev.round_done && phase_q == PH_IDLE)
                        begin
                            phase_q = PH_COUNT;
                            count_q = wait_q;
                        end
                        if (phase_q == PH_DONE)
                        begin
                            apply_q = evaluate_pack(ev.volts);
                            phase_q = PH_IDLE;
                            count_q = '0;
                        end
                    end
                end
            end
            FUNC_TICK:
            begin
                if (phase_q == PH_COUNT)
                begin
                    if (count_q <= 16'd1)
                    begin
                        count_q = '0;
                        phase_q = PH_DONE;
                    end
                    else
                        count_q = count_q - 16'd1;
                end
            end
        endcase
        return {phase_q == PH_COUNT, running_q, flags_q, stop_q, apply_q};
    endfunction

    function automatic void check_field(input string name, input int want, input int got);
        if (want != got)
        begin
            $error("%s mismatch: expected %0d, actual %0d", name, want, got);
            errors++;
        end
    endfunction

    function automatic pack_volts_t pick_volts();
        pack_volts_t volts;
        int          mode;
        int          base;
        int          spread;
        mode   = $urandom_range(0, 9);
        base   = $urandom_range(2800, 4300);
        spread = (mode < 6) ? 40 : ((mode < 8) ? 12 : 300);
        for (int c = 0; c < CELLS; c++)
        begin
            if (mode == 0)
                volts[c] = 16'($urandom);
            else if (mode == 1)
                volts[c] = $urandom_range(0, 1) ? 16'hFFFF : 16'h0000;
            else
                volts[c] = 16'(base + $urandom_range(0, spread));
        end
        return volts;
    endfunction

    task automatic add_event(input logic [1:0] func, input int v0, input int v1,
                             input int v2, input int v3, input logic done);
        balance_event_t ev;
        ev.func       = func;
        ev.round_done = done;
        ev.volts      = {16'(v3), 16'(v2), 16'(v1), 16'(v0)};
        pending_events.push_back(ev);
    endtask

    // Mostly enabled sequences of updates and ticks, with rare restarts and stops.
    task automatic queue_random_events(input int count);
        balance_event_t ev;
        int             pick;
        ev.func       = FUNC_START;
        ev.round_done = 1'($urandom_range(0, 1));
        ev.volts      = pick_volts();
        pending_events.push_back(ev);
        for (int k = 1; k < count; k++)
        begin
            pick = $urandom_range(0, 99);
            if (pick < 7)
                ev.func = FUNC_START;
            else if (pick < 11)
                ev.func = FUNC_STOP;
            else if (pick < 55)
                ev.func = FUNC_UPDATE;
            else
                ev.func = FUNC_TICK;
            ev.round_done = ($urandom_range(0, 99) < 60);
            ev.volts      = pick_volts();
            pending_events.push_back(ev);
        end
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [15:0] val);
        @(negedge clk);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        @(negedge clk);
        while (!cfg_taken)
            @(negedge clk);
        cfg_valid <= 1'b0;
    endtask

    task automatic write_all_regs(input int st, input int en, input int ce, input int wt);
        write_reg(REG_START_TH, 16'(st));
        write_reg(REG_END_TH, 16'(en));
        write_reg(REG_CEILING, 16'(ce));
        write_reg(REG_WAIT, 16'(wt));
    endtask

    // The sender holds off here until every expected result has been taken.
    // The check runs at the rising edge, where the queue and s_tvalid are settled.
    task automatic wait_until_drained();
        while (pending_events.size() != 0 || s_tvalid || due_command_words.size() != 0)
            @(posedge clk);
        repeat (3) @(negedge clk);
    endtask

    task automatic run_random_phase(input int st, input int en, input int ce,
                                    input int wt, input int count);
        write_all_regs(st, en, ce, wt);
        queue_random_events(count);
        wait_until_drained();
    endtask

    // Driver: a new event goes out once the previous transaction has been taken.
    always @(negedge clk)
    begin
        if (rst_n)
        begin
            if (!s_tvalid || in_taken)
            begin
                if (pending_events.size() != 0
                    && (steady || $urandom_range(0, 99) >= 12))
                begin
                    next_event = pending_events.pop_front();
                    s_tvalid <= 1'b1;
                    s_tuser  <= next_event.func;
                    s_tdata  <= {{(IN_W - CELLS * 16 - 1){1'b0}},
                                 next_event.round_done, next_event.volts};
                end
                else
                    s_tvalid <= 1'b0;
            end
            m_tready <= steady || ($urandom_range(0, 99) >= 12);
        end
    end

    // Monitor: results are checked and accepted events predicted at the rising edge.
    always @(posedge clk)
    begin
        cycles = cycles + 1;
        if (cycles > CYCLE_CAP)
        begin
            $display("Verification failed");
            $finish;
        end
        else
        begin
            in_taken  <= s_tvalid && s_tready;
            cfg_taken <= cfg_valid && cfg_ready;
            if (rst_n)
            begin
                if (m_tvalid && m_tready)
                begin
                    if (due_command_words.size() == 0)
                    begin
                        $error("result transaction with nothing expected: %h", m_tdata);
                        errors++;
                    end
                    else
                    begin
                        want_word = due_command_words.pop_front();
                        check_field("apply_mask", int'(want_word[0]), int'(m_tdata[0]));
                        check_field("stop_all", int'(want_word[1]), int'(m_tdata[1]));
                        check_field("balance_mask", int'(want_word[CELLS+1:2]),
                                    int'(m_tdata[CELLS+1:2]));
                        check_field("balancing_active", int'(want_word[CELLS+2]),
                                    int'(m_tdata[CELLS+2]));
                        check_field("waiting", int'(want_word[CELLS+3]),
                                    int'(m_tdata[CELLS+3]));
                    end
                end
                if (cfg_valid && cfg_ready)
                begin
                    case (cfg_index)
                        REG_START_TH: start_th_q = cfg_data;
                        REG_END_TH:   end_th_q   = cfg_data;
                        REG_CEILING:  ceiling_q  = cfg_data;
                        REG_WAIT:     wait_q     = cfg_data;
                    endcase
                end
                if (s_tvalid && s_tready)
                begin
                    due_command_words.push_back(predict_balance_event(
                        {s_tuser, s_tdata[CELLS*16], s_tdata[CELLS*16-1:0]}));
                end
            end
        end
    end

    initial
    begin
        repeat (3) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        // Reset settings: disabled events, first evaluation, hysteresis, restarts.
        add_event(FUNC_UPDATE, 3000, 3100, 3000, 3000, 1'b1);
        add_event(FUNC_TICK, 0, 0, 0, 0, 1'b0);
        add_event(FUNC_STOP, 0, 0, 0, 0, 1'b0);
        add_event(FUNC_START, 3300, 3300, 3300, 3300, 1'b0);
        add_event(FUNC_UPDATE, 3300, 3340, 3300, 3310, 1'b0);
        add_event(FUNC_UPDATE, 3300, 3340, 3300, 3310, 1'b0);
        add_event(FUNC_UPDATE, 3300, 3340, 3300, 3310, 1'b1);
        add_event(FUNC_TICK, 0, 0, 0, 0, 1'b1);
        add_event(FUNC_START, 3300, 3312, 3300, 3300, 1'b1);
        add_event(FUNC_START, 65535, 65535, 65535, 65535, 1'b0);
        add_event(FUNC_START, 0, 0, 0, 0, 1'b0);
        add_event(FUNC_STOP, 0, 0, 0, 0, 1'b1);
        wait_until_drained();

        // Short wait: the countdown runs out, expires and re-evaluates.
        write_all_regs(15, 4, 4000, 2);
        add_event(FUNC_START, 3600, 3625, 3600, 3618, 1'b0);
        add_event(FUNC_UPDATE, 3600, 3625, 3600, 3618, 1'b1);
        add_event(FUNC_UPDATE, 3600, 3625, 3600, 3618, 1'b1);
        add_event(FUNC_TICK, 0, 0, 0, 0, 1'b0);
        add_event(FUNC_TICK, 0, 0, 0, 0, 1'b0);
        add_event(FUNC_UPDATE, 3600, 3610, 3600, 3601, 1'b1);
        add_event(FUNC_UPDATE, 3600, 3610, 3600, 3601, 1'b1);
        add_event(FUNC_TICK, 0, 0, 0, 0, 1'b0);
        add_event(FUNC_TICK, 0, 0, 0, 0, 1'b0);
        add_event(FUNC_TICK, 0, 0, 0, 0, 1'b0);
        add_event(FUNC_STOP, 0, 0, 0, 0, 1'b0);
        add_event(FUNC_UPDATE, 3600, 3700, 3600, 3600, 1'b1);
        wait_until_drained();

        run_random_phase(0, 0, 65535, 1, 75);
        run_random_phase(65535, 65535, 0, 0, 75);
        run_random_phase(10, 3, 4200, 3, 75);
        run_random_phase($urandom_range(0, 200), $urandom_range(0, 60),
                         $urandom, 65535, 75);
        steady = 1'b1;
        run_random_phase(40, 8, 5000, 2, 75);
        steady = 1'b0;
        run_random_phase(20, 5, 5000, 1000, 75);

        repeat (10) @(negedge clk);
        if (errors == 0 && due_command_words.size() == 0)
            $display("Verification passed");
        else
            $display("Verification failed");
        $finish;
    end

endmodule
